[sv/cbg_pkg.sv]
// Shared types and constants for the cubic bridgeless graph checker.
// No dependencies; imported by cbg_scan and the top level.
`timescale 1ns / 1ps
`default_nettype none
package cbg_pkg;

   localparam int VERTEX_SLOTS   = 64;   // one row per 6-bit vertex id
   localparam int VID_W          = 6;
   localparam int COUNT_W        = 7;
   localparam int TOTAL_W        = 11;
   localparam int EDGE_W         = 2 * VID_W;
   localparam int CUBIC_DEGREE   = 3;
   localparam int DEGREE_CAP     = 4;
   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_MAX_EDGES  = 96;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_EMPTY        = 3'd1;
   localparam logic [2:0] ST_NOT_SIMPLE   = 3'd2;
   localparam logic [2:0] ST_NOT_CUBIC    = 3'd3;
   localparam logic [2:0] ST_DISCONNECTED = 3'd4;
   localparam logic [2:0] ST_BRIDGE       = 3'd5;

   // start command for the edge scan unit
   typedef struct packed {
      logic             start;
      logic [VID_W-1:0] key;
      logic             omit_en;
   } cbg_scan_cmd_type;

   // per-cycle result of the edge scan unit
   typedef struct packed {
      logic             hit;
      logic             done;
      logic [VID_W-1:0] other;
   } cbg_scan_hit_type;

endpackage
`default_nettype wire

[sv/cbg_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cbg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[sv/cbg_scan.sv]
// Edge scan unit: holds the edge store and sweeps it one word a cycle,
// flagging edges incident to a key vertex. Depends on cbg_pkg and cbg_ram.
`timescale 1ns / 1ps
`default_nettype none
module cbg_scan #(
   parameter int MAX_EDGES = cbg_pkg::DEF_MAX_EDGES
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                store_en,
   input  wire [$clog2(MAX_EDGES)-1:0]        store_addr,
   input  wire [cbg_pkg::EDGE_W-1:0]          store_data,
   input  wire [$clog2(MAX_EDGES+1)-1:0]      edge_count,
   input  wire [$clog2(MAX_EDGES+1)-1:0]      omit_index,
   input  cbg_pkg::cbg_scan_cmd_type          cmd,
   output cbg_pkg::cbg_scan_hit_type          res
);
   import cbg_pkg::*;

   localparam int AW = $clog2(MAX_EDGES);
   localparam int EW = $clog2(MAX_EDGES + 1);

   logic             busy_ff, busy_in;
   logic [EW-1:0]    idx_ff, idx_in;
   logic [EW-1:0]    total_ff, total_in;
   logic [EW-1:0]    omit_ff, omit_in;
   logic             omit_en_ff, omit_en_in;
   logic [VID_W-1:0] key_ff, key_in;
   logic             vld_ff, vld_in;
   logic             last_ff, last_in;
   logic [EW-1:0]    vidx_ff, vidx_in;
   logic             empty_ff, empty_in;
   logic [EDGE_W-1:0] rd_data;
   logic [VID_W-1:0] end_a, end_b;

   cbg_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (store_addr),
      .wr_data (store_data),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      total_in   = total_ff;
      omit_in    = omit_ff;
      omit_en_in = omit_en_ff;
      key_in     = key_ff;
      vld_in     = 1'b0;
      last_in    = 1'b0;
      vidx_in    = idx_ff;
      empty_in   = 1'b0;
      if (cmd.start) begin
         idx_in     = '0;
         total_in   = edge_count;
         omit_in    = omit_index;
         omit_en_in = cmd.omit_en;
         key_in     = cmd.key;
         busy_in    = (edge_count != '0);
         empty_in   = (edge_count == '0);
      end else if (busy_ff) begin
         // issue one edge word a cycle; its data lands next cycle
         vld_in  = 1'b1;
         last_in = (idx_ff == total_ff - 1'b1);
         idx_in  = idx_ff + 1'b1;
         if (last_in) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         vld_ff   <= 1'b0;
         last_ff  <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         vld_ff   <= vld_in;
         last_ff  <= last_in;
         empty_ff <= empty_in;
      end
      idx_ff     <= idx_in;
      total_ff   <= total_in;
      omit_ff    <= omit_in;
      omit_en_ff <= omit_en_in;
      key_ff     <= key_in;
      vidx_ff    <= vidx_in;
   end

   assign end_a = rd_data[EDGE_W-1:VID_W];
   assign end_b = rd_data[VID_W-1:0];

   always_comb begin
      res.hit   = vld_ff && !(omit_en_ff && (vidx_ff == omit_ff))
                  && ((end_a == key_ff) || (end_b == key_ff));
      res.other = (end_b == key_ff) ? end_a : end_b;
      res.done  = (vld_ff && last_ff) || empty_ff;
   end

endmodule
`default_nettype wire

[sv/cubic_bridgeless_graph_checker_unit.sv]
// Top level of the cubic bridgeless graph checker: edge loading, sequencer
// for degree, connectivity and bridge walks. Depends on cbg_pkg, cbg_ram, cbg_scan.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | req_tdata, req_tlast (closes a graph)
//  rsp     | out | rsp_tvalid/tready    | rsp_tdata (one word per graph)
//
// An edge word passes through an adjacency row read, then a check and write;
// a word without an edge, or one that follows a fault, skips the check. One
// walk runs for connectivity and one per edge for bridges, all through the
// single edge scan unit. Synchronous reset clears control state; no clearing
// pass is needed. req_tready is low outside S_IDLE: while an edge word is
// checked, while a graph is judged or while a result cannot be stored.
`timescale 1ns / 1ps
`default_nettype none
module cubic_bridgeless_graph_checker_unit #(
   parameter int MAX_VERTICES = cbg_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = cbg_pkg::DEF_MAX_EDGES
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [6:0] vertex_count, [7] edge_present, [13:8] edge_left, [19:14] edge_right
   input  wire  [23:0] req_tdata,
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [2:0] status, [13:3] edges_seen
   output logic [15:0] rsp_tdata
);
   import cbg_pkg::*;

   localparam int AW  = $clog2(MAX_EDGES);
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int DW  = $clog2(MAX_VERTICES + 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CHECK   = 4'd1;
   localparam logic [3:0] S_JUDGE   = 4'd2;
   localparam logic [3:0] S_DEG_GO  = 4'd3;
   localparam logic [3:0] S_DEG     = 4'd4;
   localparam logic [3:0] S_WALK_GO = 4'd5;
   localparam logic [3:0] S_POP     = 4'd6;
   localparam logic [3:0] S_POP_W   = 4'd7;
   localparam logic [3:0] S_SCAN    = 4'd8;
   localparam logic [3:0] S_WALK_END = 4'd9;
   localparam logic [3:0] S_OUT     = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic               open_ff, open_in;
   logic [COUNT_W-1:0] verts_ff, verts_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               fault_ff, fault_in;
   logic [VERTEX_SLOTS-1:0] row_valid_ff, row_valid_in;
   logic [VID_W-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [VID_W-1:0]   a_ff, a_in, b_ff, b_in;
   logic [TOTAL_W-1:0] eidx_ff, eidx_in;
   logic               row_ok_ff, row_ok_in;
   logic               last_ff, last_in;
   logic [VID_W-1:0]   v_ff, v_in;
   logic [2:0]         deg_ff, deg_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [DW-1:0]      depth_ff, depth_in;
   logic               bridge_ff, bridge_in;
   logic [EW-1:0]      omit_ff, omit_in;
   logic [2:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [TOTAL_W-1:0] rsp_edges_ff, rsp_edges_in;

   logic [COUNT_W-1:0] f_count;
   logic               f_present;
   logic [VID_W-1:0]   f_left, f_right, f_lo, f_hi;
   logic               accept;

   logic               adj_we;
   logic [VERTEX_SLOTS-1:0] adj_wdata, adj_rdata, adj_row;
   logic               stk_we;
   logic [VW-1:0]      stk_waddr, stk_raddr;
   logic [VID_W-1:0]   stk_wdata, stk_rdata;
   logic               edge_we;
   logic [EDGE_W-1:0]  edge_wdata;
   cbg_scan_cmd_type   scan_cmd;
   cbg_scan_hit_type   scan_res;
   logic [EW-1:0]      edge_count;
   logic [MAX_VERTICES-1:0] reach_mask;
   logic [2:0]         deg_next;
   logic               dup, bad;

   assign f_count   = req_tdata[6:0];
   assign f_present = req_tdata[7];
   assign f_left    = req_tdata[13:8];
   assign f_right   = req_tdata[19:14];
   assign f_lo      = (f_left < f_right) ? f_left : f_right;
   assign f_hi      = (f_left < f_right) ? f_right : f_left;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_edges_ff, rsp_status_ff};

   // adjacency kept once per pair: row = lower id, column = higher id
   cbg_ram #(.WIDTH(VERTEX_SLOTS), .DEPTH(VERTEX_SLOTS)) u_adj (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (lo_ff),
      .wr_data (adj_wdata),
      .rd_addr (f_lo),
      .rd_data (adj_rdata)
   );

   cbg_ram #(.WIDTH(VID_W), .DEPTH(MAX_VERTICES)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   cbg_scan #(.MAX_EDGES(MAX_EDGES)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .store_en   (edge_we),
      .store_addr (eidx_ff[AW-1:0]),
      .store_data (edge_wdata),
      .edge_count (edge_count),
      .omit_index (omit_ff),
      .cmd        (scan_cmd),
      .res        (scan_res)
   );

   assign edge_count = total_ff[EW-1:0];
   assign edge_wdata = {a_ff, b_ff};
   assign adj_row    = row_ok_ff ? adj_rdata : '0;
   assign dup        = adj_row[hi_ff];
   assign bad        = ({1'b0, a_ff} >= verts_ff) || ({1'b0, b_ff} >= verts_ff)
                       || (a_ff == b_ff) || dup;
   assign adj_wdata  = adj_row | (VERTEX_SLOTS'(1) << hi_ff);
   assign deg_next   = (scan_res.hit && (deg_ff < 3'(DEGREE_CAP))) ? deg_ff + 1'b1 : deg_ff;

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         reach_mask[i] = (COUNT_W'(i) < verts_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      open_in       = open_ff;
      verts_in      = verts_ff;
      total_in      = total_ff;
      fault_in      = fault_ff;
      row_valid_in  = row_valid_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      eidx_in       = eidx_ff;
      row_ok_in     = row_ok_ff;
      last_in       = last_ff;
      v_in          = v_ff;
      deg_in        = deg_ff;
      visited_in    = visited_ff;
      depth_in      = depth_ff;
      bridge_in     = bridge_ff;
      omit_in       = omit_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_edges_in  = rsp_edges_ff;
      adj_we        = 1'b0;
      edge_we       = 1'b0;
      stk_we        = 1'b0;
      stk_waddr     = depth_ff[VW-1:0];
      stk_wdata     = '0;
      stk_raddr     = VW'(depth_ff - 1'b1);
      scan_cmd      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!open_ff) begin
                  // new graph: drop adjacency, counts and fault
                  verts_in     = f_count;
                  total_in     = '0;
                  fault_in     = 1'b0;
                  row_valid_in = '0;
               end
               open_in   = !req_tlast;
               last_in   = req_tlast;
               a_in      = f_left;
               b_in      = f_right;
               lo_in     = f_lo;
               hi_in     = f_hi;
               row_ok_in = open_ff && row_valid_ff[f_lo];
               if (f_present) begin
                  eidx_in  = open_ff ? total_ff : '0;
                  total_in = (eidx_in == '1) ? eidx_in : eidx_in + 1'b1;
               end
               if (f_present && !(open_ff && fault_ff)) begin
                  state_in = S_CHECK;
               end else if (req_tlast) begin
                  state_in = S_JUDGE;
               end
            end
         end
         S_CHECK: begin
            if (bad) begin
               fault_in = 1'b1;
            end else begin
               adj_we = 1'b1;
               row_valid_in[lo_ff] = 1'b1;
               edge_we = (eidx_ff < TOTAL_W'(MAX_EDGES));
            end
            state_in = last_ff ? S_JUDGE : S_IDLE;
         end
         S_JUDGE: begin
            if (verts_ff == '0) begin
               status_in = ST_EMPTY;
               state_in  = S_OUT;
            end else if (fault_ff) begin
               status_in = ST_NOT_SIMPLE;
               state_in  = S_OUT;
            end else if ((verts_ff > COUNT_W'(MAX_VERTICES))
                         || (total_ff > TOTAL_W'(MAX_EDGES))) begin
               status_in = ST_NOT_CUBIC;
               state_in  = S_OUT;
            end else begin
               v_in     = '0;
               state_in = S_DEG_GO;
            end
         end
         S_DEG_GO: begin
            scan_cmd.start = 1'b1;
            scan_cmd.key   = v_ff;
            deg_in         = '0;
            state_in       = S_DEG;
         end
         S_DEG: begin
            deg_in = deg_next;
            if (scan_res.done) begin
               if (deg_next != 3'(CUBIC_DEGREE)) begin
                  status_in = ST_NOT_CUBIC;
                  state_in  = S_OUT;
               end else if ({1'b0, v_ff} == verts_ff - 1'b1) begin
                  bridge_in = 1'b0;
                  state_in  = S_WALK_GO;
               end else begin
                  v_in     = v_ff + 1'b1;
                  state_in = S_DEG_GO;
               end
            end
         end
         S_WALK_GO: begin
            // seed the walk at vertex 0
            visited_in = MAX_VERTICES'(1);
            stk_we     = 1'b1;
            stk_waddr  = '0;
            stk_wdata  = '0;
            depth_in   = DW'(1);
            state_in   = S_POP;
         end
         S_POP: begin
            if (depth_ff == '0) begin
               state_in = S_WALK_END;
            end else begin
               depth_in = depth_ff - 1'b1;
               state_in = S_POP_W;
            end
         end
         S_POP_W: begin
            scan_cmd.start   = 1'b1;
            scan_cmd.key     = stk_rdata;
            scan_cmd.omit_en = bridge_ff;
            state_in         = S_SCAN;
         end
         S_SCAN: begin
            if (scan_res.hit && !visited_ff[scan_res.other[VW-1:0]]) begin
               visited_in[scan_res.other[VW-1:0]] = 1'b1;
               stk_we    = 1'b1;
               stk_wdata = scan_res.other;
               depth_in  = depth_ff + 1'b1;
            end
            if (scan_res.done) begin
               state_in = S_POP;
            end
         end
         S_WALK_END: begin
            if (visited_ff != reach_mask) begin
               status_in = bridge_ff ? ST_BRIDGE : ST_DISCONNECTED;
               state_in  = S_OUT;
            end else if (!bridge_ff) begin
               bridge_in = 1'b1;
               omit_in   = '0;
               state_in  = S_WALK_GO;
            end else if (omit_ff == edge_count - 1'b1) begin
               status_in = ST_OK;
               state_in  = S_OUT;
            end else begin
               omit_in  = omit_ff + 1'b1;
               state_in = S_WALK_GO;
            end
         end
         S_OUT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_edges_in  = total_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= 1'b0;
         verts_ff     <= '0;
         total_ff     <= '0;
         fault_ff     <= 1'b0;
         row_valid_ff <= '0;
         visited_ff   <= '0;
         depth_ff     <= '0;
         bridge_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         verts_ff     <= verts_in;
         total_ff     <= total_in;
         fault_ff     <= fault_in;
         row_valid_ff <= row_valid_in;
         visited_ff   <= visited_in;
         depth_ff     <= depth_in;
         bridge_ff    <= bridge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      eidx_ff       <= eidx_in;
      row_ok_ff     <= row_ok_in;
      last_ff       <= last_in;
      v_ff          <= v_in;
      deg_ff        <= deg_in;
      omit_ff       <= omit_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_edges_ff  <= rsp_edges_in;
   end

endmodule
`default_nettype wire
